// ===== hdl/rpw_pkg.sv =====
// Shared types and constants for the rotated pixel writer.
`default_nettype none

package rpw_pkg;

    localparam int ROT_W   = 2;
    localparam int DIM_W   = 13;
    localparam int LINE_W  = 15;
    localparam int BPP_W   = 7;
    localparam int FMT_W   = 11;
    localparam int COORD_W = 16;
    localparam int COLOR_W = 24;
    localparam int STAT_W  = 2;
    localparam int OFFS_W  = 26;
    localparam int DATA_W  = 32;
    localparam int CNT_W   = 3;
    localparam int IDX_W   = 3;
    localparam int CFG_W   = 15;

    localparam int ROW_W   = DIM_W + LINE_W;   // py * line_bytes
    localparam int COL_W   = DIM_W + CNT_W;    // px * bytes
    localparam int SUM_W   = ROW_W + 1;

    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 64;

    // Exact n/255 for any 32-bit n: (n * RECIP_255) >> 39
    localparam logic [31:0] RECIP_255 = 32'h8080_8081;
    localparam int          RECIP_SH  = 39;
    localparam int          QUOT_W    = 64 - RECIP_SH;

    localparam logic [31:0] ROUND_ADD = 32'd127;

    typedef enum logic [ROT_W-1:0] {
        ROT_0   = 2'd0,
        ROT_90  = 2'd1,
        ROT_180 = 2'd2,
        ROT_270 = 2'd3
    } rot_t;

    typedef enum logic [STAT_W-1:0] {
        ST_WRITTEN = 2'd0,
        ST_CLIPPED = 2'd1,
        ST_DEPTH   = 2'd2,
        ST_BEYOND  = 2'd3
    } status_t;

    typedef enum logic [IDX_W-1:0] {
        REG_ROTATION    = 3'd0,
        REG_PHYS_WIDTH  = 3'd1,
        REG_PHYS_HEIGHT = 3'd2,
        REG_LINE_BYTES  = 3'd3,
        REG_PIXEL_BITS  = 3'd4,
        REG_RED_FORMAT  = 3'd5,
        REG_GREEN_FMT   = 3'd6,
        REG_BLUE_FORMAT = 3'd7
    } cfg_index_t;

endpackage

`default_nettype wire

// ===== hdl/rpw_scale.sv =====
// Scales one 8-bit colour component to its field length and offset (two stages).
`default_nettype none

module rpw_scale (
    input  wire logic                          aclk,
    input  wire logic                          en,
    input  wire logic [7:0]                    comp,
    input  wire logic [rpw_pkg::FMT_W-1:0]     fmt,
    output logic      [rpw_pkg::DATA_W-1:0]    field
);

    logic [5:0]                     len;
    logic [31:0]                    prod;
    logic [31:0]                    num_next;
    logic [31:0]                    num_reg;
    logic [4:0]                     off_s2_reg;
    logic [63:0]                    recip_mul;
    logic [rpw_pkg::QUOT_W-1:0]     quot_reg;
    logic [4:0]                     off_s3_reg;

    assign len = fmt[5:0];

    // v * (2^len - 1) wrapped at 32 bits is (v << len) - v; len >= 32 leaves -v
    always_comb begin
        if (len >= 6'd32) begin
            prod = 32'd0 - 32'(comp);
        end else begin
            prod = (32'(comp) << len[4:0]) - 32'(comp);
        end
        num_next = prod + rpw_pkg::ROUND_ADD;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            num_reg    <= num_next;
            off_s2_reg <= fmt[10:6];
        end
    end

    assign recip_mul = 64'(num_reg) * 64'(rpw_pkg::RECIP_255);

    always_ff @(posedge aclk) begin
        if (en) begin
            quot_reg   <= recip_mul[63:rpw_pkg::RECIP_SH];
            off_s3_reg <= off_s2_reg;
        end
    end

    assign field = rpw_pkg::DATA_W'(quot_reg) << off_s3_reg;

endmodule

`default_nettype wire

// ===== hdl/rotated_pixel_writer_unit.sv =====
// Top level: clip, rotate, scale and pack one pixel write per item.
//
//  channel   dir  handshake            payload
//  s_        in   s_tvalid/s_tready    x_pos, y_pos, color
//  m_        out  m_tvalid/m_tready    status, byte_offset, write_data, byte_count
//  cfg_      in   cfg_wr_en            cfg_index, cfg_wdata
//
// One item per cycle. Four register stages: input register, clip/map stage,
// multiplier stage (row offset, store size, reciprocal divide by 255), then
// the offset add, bound compare and packing into the result register.
// aresetn clears the valid bits and loads the register defaults; s_tready is
// low while it is held.
// A stalled result holds the whole pipeline; s_tready follows that stall.
`default_nettype none

module rotated_pixel_writer_unit #(
    parameter int MAX_DIM        = 4096,
    parameter int MAX_LINE_BYTES = 16384
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // [15:0] x_pos, [31:16] y_pos, [55:32] color
    input  wire logic [rpw_pkg::IN_TDATA_W-1:0]     s_tdata,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // [1:0] status, [27:2] byte_offset, [59:28] write_data, [62:60] byte_count
    output logic      [rpw_pkg::OUT_TDATA_W-1:0]    m_tdata,
    input  wire logic                               cfg_wr_en,
    input  wire logic [rpw_pkg::IDX_W-1:0]          cfg_index,
    input  wire logic [rpw_pkg::CFG_W-1:0]          cfg_wdata
);

    localparam int DIM_W  = rpw_pkg::DIM_W;
    localparam int LINE_W = rpw_pkg::LINE_W;

    // configuration
    rpw_pkg::rot_t                  rotation_reg;
    logic [DIM_W-1:0]               phys_width_reg;
    logic [DIM_W-1:0]               phys_height_reg;
    logic [LINE_W-1:0]              line_bytes_reg;
    logic [rpw_pkg::BPP_W-1:0]      pixel_bits_reg;
    logic [rpw_pkg::FMT_W-1:0]      red_fmt_reg;
    logic [rpw_pkg::FMT_W-1:0]      green_fmt_reg;
    logic [rpw_pkg::FMT_W-1:0]      blue_fmt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rotation_reg    <= rpw_pkg::ROT_0;
            phys_width_reg  <= DIM_W'(640);
            phys_height_reg <= DIM_W'(480);
            line_bytes_reg  <= LINE_W'(2560);
            pixel_bits_reg  <= rpw_pkg::BPP_W'(32);
            red_fmt_reg     <= rpw_pkg::FMT_W'(1032);
            green_fmt_reg   <= rpw_pkg::FMT_W'(520);
            blue_fmt_reg    <= rpw_pkg::FMT_W'(8);
        end else if (cfg_wr_en) begin
            case (rpw_pkg::cfg_index_t'(cfg_index))
                rpw_pkg::REG_ROTATION: begin
                    rotation_reg <= rpw_pkg::rot_t'(cfg_wdata[1:0]);
                end
                rpw_pkg::REG_PHYS_WIDTH: begin
                    phys_width_reg <= (32'(cfg_wdata[DIM_W-1:0]) > 32'(MAX_DIM)) ?
                                      DIM_W'(MAX_DIM) : cfg_wdata[DIM_W-1:0];
                end
                rpw_pkg::REG_PHYS_HEIGHT: begin
                    phys_height_reg <= (32'(cfg_wdata[DIM_W-1:0]) > 32'(MAX_DIM)) ?
                                       DIM_W'(MAX_DIM) : cfg_wdata[DIM_W-1:0];
                end
                rpw_pkg::REG_LINE_BYTES: begin
                    line_bytes_reg <= (32'(cfg_wdata) > 32'(MAX_LINE_BYTES)) ?
                                      LINE_W'(MAX_LINE_BYTES) : cfg_wdata;
                end
                rpw_pkg::REG_PIXEL_BITS: begin
                    pixel_bits_reg <= cfg_wdata[rpw_pkg::BPP_W-1:0];
                end
                rpw_pkg::REG_RED_FORMAT: begin
                    red_fmt_reg <= cfg_wdata[rpw_pkg::FMT_W-1:0];
                end
                rpw_pkg::REG_GREEN_FMT: begin
                    green_fmt_reg <= cfg_wdata[rpw_pkg::FMT_W-1:0];
                end
                rpw_pkg::REG_BLUE_FORMAT: begin
                    blue_fmt_reg <= cfg_wdata[rpw_pkg::FMT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // pipeline control: everything moves unless the result is held
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic en;

    assign en       = !v4_reg || m_tready;
    assign s_tready = en && aresetn;
    assign m_tvalid = v4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // stage 1: input register
    logic [rpw_pkg::COORD_W-1:0]    x_reg;
    logic [rpw_pkg::COORD_W-1:0]    y_reg;
    logic [rpw_pkg::COLOR_W-1:0]    color_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg     <= s_tdata[15:0];
            y_reg     <= s_tdata[31:16];
            color_reg <= s_tdata[55:32];
        end
    end

    // clip against the logical size and map to physical coordinates
    logic                   swap;
    logic [DIM_W-1:0]       lw;
    logic [DIM_W-1:0]       lh;
    logic                   clipped;
    logic [DIM_W-1:0]       xs;
    logic [DIM_W-1:0]       ys;
    logic [DIM_W-1:0]       px;
    logic [DIM_W-1:0]       py;
    logic [7:0]             bits_sum;
    logic [4:0]             bytes_full;
    rpw_pkg::status_t       status_s1;

    always_comb begin
        swap = (rotation_reg == rpw_pkg::ROT_90) || (rotation_reg == rpw_pkg::ROT_270);
        lw   = swap ? phys_height_reg : phys_width_reg;
        lh   = swap ? phys_width_reg : phys_height_reg;
        clipped = x_reg[15] || y_reg[15] ||
                  (x_reg[14:0] >= 15'(lw)) || (y_reg[14:0] >= 15'(lh));
        xs = x_reg[DIM_W-1:0];
        ys = y_reg[DIM_W-1:0];
        case (rotation_reg)
            rpw_pkg::ROT_90: begin
                px = phys_width_reg - DIM_W'(1) - ys;
                py = xs;
            end
            rpw_pkg::ROT_180: begin
                px = phys_width_reg - DIM_W'(1) - xs;
                py = phys_height_reg - DIM_W'(1) - ys;
            end
            rpw_pkg::ROT_270: begin
                px = ys;
                py = lw - DIM_W'(1) - xs;
            end
            default: begin
                px = xs;
                py = ys;
            end
        endcase
        bits_sum   = 8'(pixel_bits_reg) + 8'd7;
        bytes_full = bits_sum[7:3];
        if (clipped) begin
            status_s1 = rpw_pkg::ST_CLIPPED;
        end else if (bytes_full == 5'd0 || bytes_full > 5'd4) begin
            status_s1 = rpw_pkg::ST_DEPTH;
        end else begin
            status_s1 = rpw_pkg::ST_WRITTEN;
        end
    end

    // stage 2
    rpw_pkg::status_t               status_s2_reg;
    logic [DIM_W-1:0]               px_reg;
    logic [DIM_W-1:0]               py_reg;
    logic [rpw_pkg::CNT_W-1:0]      bytes_s2_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            status_s2_reg <= status_s1;
            px_reg        <= px;
            py_reg        <= py;
            bytes_s2_reg  <= bytes_full[rpw_pkg::CNT_W-1:0];
        end
    end

    // stage 3: products registered
    rpw_pkg::status_t               status_s3_reg;
    logic [rpw_pkg::ROW_W-1:0]      row_off_reg;
    logic [rpw_pkg::COL_W-1:0]      col_off_reg;
    logic [rpw_pkg::ROW_W-1:0]      store_reg;
    logic [rpw_pkg::CNT_W-1:0]      bytes_s3_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            status_s3_reg <= status_s2_reg;
            row_off_reg   <= rpw_pkg::ROW_W'(py_reg) * rpw_pkg::ROW_W'(line_bytes_reg);
            col_off_reg   <= rpw_pkg::COL_W'(px_reg) * rpw_pkg::COL_W'(bytes_s2_reg);
            store_reg     <= rpw_pkg::ROW_W'(line_bytes_reg) *
                             rpw_pkg::ROW_W'(phys_height_reg);
            bytes_s3_reg  <= bytes_s2_reg;
        end
    end

    logic [rpw_pkg::DATA_W-1:0] red_field;
    logic [rpw_pkg::DATA_W-1:0] green_field;
    logic [rpw_pkg::DATA_W-1:0] blue_field;

    rpw_scale u_scale_red (
        .aclk  (aclk),
        .en    (en),
        .comp  (color_reg[23:16]),
        .fmt   (red_fmt_reg),
        .field (red_field)
    );

    rpw_scale u_scale_green (
        .aclk  (aclk),
        .en    (en),
        .comp  (color_reg[15:8]),
        .fmt   (green_fmt_reg),
        .field (green_field)
    );

    rpw_scale u_scale_blue (
        .aclk  (aclk),
        .en    (en),
        .comp  (color_reg[7:0]),
        .fmt   (blue_fmt_reg),
        .field (blue_field)
    );

    // final stage: offset, bound check, pack
    logic [rpw_pkg::SUM_W-1:0]      offset;
    logic [rpw_pkg::SUM_W-1:0]      end_off;
    logic [rpw_pkg::DATA_W-1:0]     packed_data;
    logic [rpw_pkg::DATA_W-1:0]     byte_mask;
    rpw_pkg::status_t               status_next;
    logic [rpw_pkg::OFFS_W-1:0]     offset_next;
    logic [rpw_pkg::DATA_W-1:0]     data_next;
    logic [rpw_pkg::CNT_W-1:0]      count_next;

    always_comb begin
        offset  = rpw_pkg::SUM_W'(row_off_reg) + rpw_pkg::SUM_W'(col_off_reg);
        end_off = offset + rpw_pkg::SUM_W'(bytes_s3_reg);
        case (bytes_s3_reg)
            3'd1:    byte_mask = 32'h0000_00FF;
            3'd2:    byte_mask = 32'h0000_FFFF;
            3'd3:    byte_mask = 32'h00FF_FFFF;
            default: byte_mask = 32'hFFFF_FFFF;
        endcase
        packed_data = (red_field | green_field | blue_field) & byte_mask;
        status_next = status_s3_reg;
        if (status_s3_reg == rpw_pkg::ST_WRITTEN &&
            end_off > rpw_pkg::SUM_W'(store_reg)) begin
            status_next = rpw_pkg::ST_BEYOND;
        end
        if (status_next == rpw_pkg::ST_WRITTEN) begin
            offset_next = offset[rpw_pkg::OFFS_W-1:0];
            data_next   = packed_data;
            count_next  = bytes_s3_reg;
        end else begin
            offset_next = '0;
            data_next   = '0;
            count_next  = '0;
        end
    end

    rpw_pkg::status_t               status_reg;
    logic [rpw_pkg::OFFS_W-1:0]     offset_reg;
    logic [rpw_pkg::DATA_W-1:0]     data_reg;
    logic [rpw_pkg::CNT_W-1:0]      count_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            status_reg <= status_next;
            offset_reg <= offset_next;
            data_reg   <= data_next;
            count_reg  <= count_next;
        end
    end

    assign m_tdata = {1'b0, count_reg, data_reg, offset_reg, status_reg};

endmodule

`default_nettype wire

// ===== verif/rpw_write_checker.sv =====
// Watches the pixel and result channels, predicts each write and compares the outcome.
module rpw_write_checker #(
    parameter int MAX_DIM        = 4096,
    parameter int MAX_LINE_BYTES = 16384
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [rpw_pkg::IN_TDATA_W-1:0]    s_tdata,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [rpw_pkg::OUT_TDATA_W-1:0]   m_tdata,
    input  logic                              cfg_wr_en,
    input  logic [rpw_pkg::IDX_W-1:0]         cfg_index,
    input  logic [rpw_pkg::CFG_W-1:0]         cfg_wdata,
    output int                                fail_count,
    output int                                pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import rpw_pkg::*;

    // field order from the top bit down matches m_tdata[62:0]
    typedef struct packed {
        logic [CNT_W-1:0]  byte_count;
        logic [DATA_W-1:0] write_data;
        logic [OFFS_W-1:0] byte_offset;
        status_t           status;
    } pixel_write_t;

    rot_t              cur_rot;
    logic [DIM_W-1:0]  cur_width;
    logic [DIM_W-1:0]  cur_height;
    logic [LINE_W-1:0] cur_line;
    logic [BPP_W-1:0]  cur_bits;
    logic [FMT_W-1:0]  cur_red;
    logic [FMT_W-1:0]  cur_green;
    logic [FMT_W-1:0]  cur_blue;

    pixel_write_t expected_writes[$];

    initial begin
        fail_count = 0;
        pending    = 0;
    end

    function automatic logic [DIM_W-1:0] clamp_dim(logic [CFG_W-1:0] v);
        return (v[DIM_W-1:0] > MAX_DIM) ? DIM_W'(MAX_DIM) : v[DIM_W-1:0];
    endfunction

    function automatic logic [LINE_W-1:0] clamp_line(logic [CFG_W-1:0] v);
        return (v > MAX_LINE_BYTES) ? LINE_W'(MAX_LINE_BYTES) : v[LINE_W-1:0];
    endfunction

    // (v * max + 127) / 255 with 32-bit wrap, then shifted to the field offset
    function automatic logic [31:0] scale_channel(logic [7:0] v, logic [FMT_W-1:0] fmt);
        logic [5:0]  len;
        logic [4:0]  off;
        logic [31:0] maxv;
        logic [31:0] acc;
        len = fmt[5:0];
        off = fmt[10:6];
        if (len == 0)
            return '0;
        maxv = (len >= 32) ? 32'hFFFF_FFFF : ((32'd1 << len) - 32'd1);
        acc  = {24'd0, v} * maxv + 32'd127;
        return (acc / 32'd255) << off;
    endfunction

    function automatic pixel_write_t predict_write(logic [15:0] xr, logic [15:0] yr,
                                                   logic [23:0] col);
        pixel_write_t     r;
        logic             swap;
        logic [DIM_W-1:0] lw;
        logic [DIM_W-1:0] lh;
        logic [15:0]      px;
        logic [15:0]      py;
        logic [31:0]      bytes;
        logic [63:0]      offs;
        logic [63:0]      store;
        logic [31:0]      pix;
        r    = '0;
        swap = (cur_rot == ROT_90) || (cur_rot == ROT_270);
        lw   = swap ? cur_height : cur_width;
        lh   = swap ? cur_width : cur_height;
        if (xr[15] || yr[15] || xr >= 16'(lw) || yr >= 16'(lh)) begin
            r.status = ST_CLIPPED;
            return r;
        end
        case (cur_rot)
            ROT_90: begin
                px = 16'(cur_width) - 16'd1 - yr;
                py = xr;
            end
            ROT_180: begin
                px = 16'(cur_width) - 16'd1 - xr;
                py = 16'(cur_height) - 16'd1 - yr;
            end
            ROT_270: begin
                px = yr;
                py = 16'(lw) - 16'd1 - xr;
            end
            default: begin
                px = xr;
                py = yr;
            end
        endcase
        bytes = (32'(cur_bits) + 32'd7) / 32'd8;
        if (bytes == 0 || bytes > 4) begin
            r.status = ST_DEPTH;
            return r;
        end
        offs  = 64'(py) * 64'(cur_line) + 64'(px) * 64'(bytes);
        store = 64'(cur_line) * 64'(cur_height);
        if (offs + 64'(bytes) > store) begin
            r.status = ST_BEYOND;
            return r;
        end
        pix = scale_channel(col[23:16], cur_red) | scale_channel(col[15:8], cur_green) |
              scale_channel(col[7:0], cur_blue);
        if (bytes < 4)
            pix &= (32'd1 << (bytes * 8)) - 32'd1;
        r.status      = ST_WRITTEN;
        r.byte_offset = offs[OFFS_W-1:0];
        r.write_data  = pix;
        r.byte_count  = bytes[CNT_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("%0t ns: mismatch in %s: got %0h, expected %0h", $realtime, what, got, want);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        pixel_write_t got;
        pixel_write_t want;
        if (!aresetn) begin
            cur_rot    = ROT_0;
            cur_width  = 13'd640;
            cur_height = 13'd480;
            cur_line   = 15'd2560;
            cur_bits   = 7'd32;
            cur_red    = 11'd1032;
            cur_green  = 11'd520;
            cur_blue   = 11'd8;
            expected_writes.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index_t'(cfg_index))
                    REG_ROTATION:    cur_rot    = rot_t'(cfg_wdata[ROT_W-1:0]);
                    REG_PHYS_WIDTH:  cur_width  = clamp_dim(cfg_wdata);
                    REG_PHYS_HEIGHT: cur_height = clamp_dim(cfg_wdata);
                    REG_LINE_BYTES:  cur_line   = clamp_line(cfg_wdata);
                    REG_PIXEL_BITS:  cur_bits   = cfg_wdata[BPP_W-1:0];
                    REG_RED_FORMAT:  cur_red    = cfg_wdata[FMT_W-1:0];
                    REG_GREEN_FMT:   cur_green  = cfg_wdata[FMT_W-1:0];
                    REG_BLUE_FORMAT: cur_blue   = cfg_wdata[FMT_W-1:0];
                    default: ;
                endcase
            end
            // results first, so an item taken on this edge cannot match its own slot
            if (m_tvalid && m_tready) begin
                got = pixel_write_t'(m_tdata[62:0]);
                if (expected_writes.size() == 0) begin
                    report_mismatch("unexpected result", 64'(m_tdata), '0);
                end else begin
                    want = expected_writes.pop_front();
                    if (got.status != want.status)
                        report_mismatch("status", 64'(got.status), 64'(want.status));
                    if (got.byte_offset != want.byte_offset)
                        report_mismatch("byte_offset", 64'(got.byte_offset),
                                        64'(want.byte_offset));
                    if (got.write_data != want.write_data)
                        report_mismatch("write_data", 64'(got.write_data),
                                        64'(want.write_data));
                    if (got.byte_count != want.byte_count)
                        report_mismatch("byte_count", 64'(got.byte_count),
                                        64'(want.byte_count));
                end
            end
            if (s_tvalid && s_tready)
                expected_writes.push_back(predict_write(s_tdata[15:0], s_tdata[31:16],
                                                        s_tdata[55:32]));
        end
        pending = expected_writes.size();
    end

endmodule

// ===== verif/rotated_pixel_writer_unit_test.sv =====
// Stimulus and verdict for the rotated pixel writer, checked by rpw_write_checker.
module rotated_pixel_writer_unit_test;
    timeunit 1ns;
    timeprecision 1ps;
    import rpw_pkg::*;

    localparam int IDLE_LIMIT   = 2000;
    localparam int RANDOM_ITEMS = 700;
    localparam int DIM_LIMIT    = 4096;

    logic                     aclk      = 1'b0;
    logic                     aresetn   = 1'b0;
    logic                     s_tvalid  = 1'b0;
    logic                     s_tready;
    // [15:0] x_pos, [31:16] y_pos, [55:32] color
    logic [IN_TDATA_W-1:0]    s_tdata   = '0;
    logic                     m_tvalid;
    logic                     m_tready  = 1'b0;
    // [1:0] status, [27:2] byte_offset, [59:28] write_data, [62:60] byte_count
    logic [OUT_TDATA_W-1:0]   m_tdata;
    logic                     cfg_wr_en = 1'b0;
    cfg_index_t               cfg_index = REG_ROTATION;
    logic [CFG_W-1:0]         cfg_wdata = '0;

    int   fail_count;
    int   pending;
    int   idle_cycles = 0;
    bit   steady_src  = 1'b0;
    bit   steady_snk  = 1'b0;
    logic [CFG_W-1:0] next_cfg [8];

    rotated_pixel_writer_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    rpw_write_checker checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #10 aclk = ~aclk;

    always @(negedge aclk) begin
        m_tready <= steady_snk ? 1'b1 : ($urandom_range(0, 99) >= 34);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_pixel(logic [15:0] x, logic [15:0] y, logic [23:0] color);
        while (!steady_src && $urandom_range(0, 99) < 34) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {color, y, x};
        do
            @(posedge aclk);
        while (!s_tready);
        @(negedge aclk);
    endtask

    // stop sending and wait for every outstanding item to come back
    task automatic drain();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (pending != 0)
            @(negedge aclk);
    endtask

    // registers are only written with the pipeline empty
    task automatic apply_config();
        drain();
        for (int i = 0; i < 8; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= cfg_index_t'(i);
            cfg_wdata <= next_cfg[i];
            @(negedge aclk);
        end
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic set_config(int rot, int w, int h, int line, int bpp, int r, int g, int b);
        next_cfg[REG_ROTATION]    = CFG_W'(rot);
        next_cfg[REG_PHYS_WIDTH]  = CFG_W'(w);
        next_cfg[REG_PHYS_HEIGHT] = CFG_W'(h);
        next_cfg[REG_LINE_BYTES]  = CFG_W'(line);
        next_cfg[REG_PIXEL_BITS]  = CFG_W'(bpp);
        next_cfg[REG_RED_FORMAT]  = CFG_W'(r);
        next_cfg[REG_GREEN_FMT]   = CFG_W'(g);
        next_cfg[REG_BLUE_FORMAT] = CFG_W'(b);
        apply_config();
    endtask

    function automatic int pick_dim();
        case ($urandom_range(0, 19))
            0:       return 0;
            1:       return $urandom_range(DIM_LIMIT + 1, 8191);
            2:       return DIM_LIMIT;
            3, 4:    return $urandom_range(1, DIM_LIMIT);
            default: return $urandom_range(1, 48);
        endcase
    endfunction

    function automatic int pick_format();
        if ($urandom_range(0, 3) == 0)
            return $urandom_range(0, 2047);
        return ($urandom_range(0, 31) << 6) | $urandom_range(1, 10);
    endfunction

    task automatic randomise_config();
        int w;
        int h;
        int bpp;
        int bytes;
        int line;
        w = pick_dim();
        h = pick_dim();
        case ($urandom_range(0, 9))
            0:       bpp = $urandom_range(0, 127);
            1:       bpp = 0;
            default: bpp = 8 * $urandom_range(1, 4) - $urandom_range(0, 7);
        endcase
        bytes = (bpp + 7) / 8;
        if (bytes == 0 || bytes > 4)
            bytes = 4;
        // stride mostly fits the line; sometimes short, so writes run off the store
        case ($urandom_range(0, 9))
            0:       line = $urandom_range(1, 32767);
            1:       line = $urandom_range(1, (w * bytes > 1) ? w * bytes : 1);
            default: line = ((w < DIM_LIMIT) ? w : DIM_LIMIT) * bytes + $urandom_range(0, 16);
        endcase
        if (line > 32767)
            line = 32767;
        if (line < 1)
            line = 1;
        set_config($urandom_range(0, 3), w, h, line, bpp, pick_format(), pick_format(),
                   pick_format());
    endtask

    // logical extent along x (want_y = 0) or y (want_y = 1) under next_cfg
    function automatic int logical_extent(bit want_y);
        bit   swap;
        logic [CFG_W-1:0] v;
        swap = next_cfg[REG_ROTATION][0];
        v    = (swap ^ want_y) ? next_cfg[REG_PHYS_HEIGHT] : next_cfg[REG_PHYS_WIDTH];
        return (int'(v[DIM_W-1:0]) > DIM_LIMIT) ? DIM_LIMIT : int'(v[DIM_W-1:0]);
    endfunction

    function automatic logic [15:0] pick_coord(int lim);
        case ($urandom_range(0, 9))
            0:       return 16'($urandom);
            1:       return 16'(lim + $urandom_range(0, 3));
            2:       return 16'hFFFF - 16'($urandom_range(0, 3));
            default: return (lim > 0) ? 16'($urandom_range(0, lim - 1)) :
                                        16'($urandom_range(0, 3));
        endcase
    endfunction

    function automatic logic [23:0] pick_color();
        case ($urandom_range(0, 9))
            0:       return 24'hFF_FFFF;
            1:       return 24'h00_0000;
            default: return 24'($urandom);
        endcase
    endfunction

    initial begin
        int sent;
        int phase;
        int count;
        int lw;
        int lh;
        next_cfg[REG_ROTATION]    = 15'd0;
        next_cfg[REG_PHYS_WIDTH]  = 15'd640;
        next_cfg[REG_PHYS_HEIGHT] = 15'd480;
        next_cfg[REG_LINE_BYTES]  = 15'd2560;
        next_cfg[REG_PIXEL_BITS]  = 15'd32;
        next_cfg[REG_RED_FORMAT]  = 15'd1032;
        next_cfg[REG_GREEN_FMT]   = 15'd520;
        next_cfg[REG_BLUE_FORMAT] = 15'd8;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // register defaults: corners, edges just outside, negative and huge coordinates
        send_pixel(16'd0, 16'd0, 24'h00_0000);
        send_pixel(16'd639, 16'd479, 24'hFF_FFFF);
        send_pixel(16'd640, 16'd0, 24'h12_3456);
        send_pixel(16'd0, 16'd480, 24'h65_4321);
        send_pixel(16'hFFFF, 16'd5, 24'hAB_CDEF);
        send_pixel(16'd3, 16'h8000, 24'h0F_0F0F);
        send_pixel(16'h7FFF, 16'h7FFF, 24'hF0_F0F0);
        send_pixel(16'd100, 16'd200, 24'h80_FF01);

        // quarter turn, 32-bit and full-width field lengths
        set_config(1, 8, 4, 32, 32, 32, 2047, 0);
        send_pixel(16'd0, 16'd0, 24'hFF_FFFF);
        send_pixel(16'd3, 16'd7, 24'h80_0080);
        send_pixel(16'd4, 16'd0, 24'h11_2233);
        send_pixel(16'd0, 16'd8, 24'h44_5566);

        // half turn, oversized sizes saturate, 565 layout in 24 bits
        set_config(2, 8191, 4096, 32767, 24, (11 << 6) | 5, (5 << 6) | 6, 5);
        send_pixel(16'd0, 16'd0, 24'hFF_FFFF);
        send_pixel(16'd4095, 16'd4095, 24'h7F_8001);
        send_pixel(16'd4096, 16'd0, 24'h01_0203);

        // three quarter turn with a short stride: last write runs past the store
        set_config(3, 5, 3, 2, 8, 3, (3 << 6) | 3, (6 << 6) | 2);
        send_pixel(16'd0, 16'd0, 24'hFF_FFFF);
        send_pixel(16'd2, 16'd4, 24'hC0_4080);
        send_pixel(16'd0, 16'd4, 24'h33_CC55);

        // unsupported depths, then zero width
        set_config(0, 16, 16, 64, 0, 1032, 520, 8);
        send_pixel(16'd1, 16'd1, 24'h12_3456);
        set_config(0, 16, 16, 64, 33, 1032, 520, 8);
        send_pixel(16'd1, 16'd1, 24'h12_3456);
        set_config(0, 0, 16, 64, 32, 1032, 520, 8);
        send_pixel(16'd0, 16'd0, 24'h12_3456);

        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            drain();
            randomise_config();
            lw    = logical_extent(1'b0);
            lh    = logical_extent(1'b1);
            count = $urandom_range(25, 60);
            steady_src <= (phase == 4);
            steady_snk <= (phase == 4);
            for (int i = 0; i < count; i++) begin
                if (phase == 2 && i == count / 2)
                    drain();
                send_pixel(pick_coord(lw), pick_coord(lh), pick_color());
            end
            sent  += count;
            phase++;
        end

        drain();
        repeat (10) @(negedge aclk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
